FILE: hdl/bb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, register codes and divide helpers for the 3x3 box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int CFG_W     = 12;   // config register width
    localparam int CFG_IDX_W = 1;    // config register index width
    localparam int SUM_W     = 12;   // nine 8-bit samples
    localparam int CNT_W     = 4;    // pixels in a window, 1..9

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_frame;
        logic       last_of_run;
    } res_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV_A,
        ST_DIV_B
    } bb3_state_t;

    // floor(y / 3), y < 4096: low reciprocal estimate, then one correction
    function automatic logic [11:0] div_by3(input logic [11:0] y);
        logic [23:0] p;
        logic [11:0] q0;
        logic [13:0] t;
        p  = 24'(y) * 24'd2730;
        q0 = 12'(p[23:13]);
        t  = 14'(y) - 14'(q0) * 14'd3;
        return (t >= 14'd3) ? q0 + 12'd1 : q0;
    endfunction

    // floor(y / 9), y < 4096
    function automatic logic [11:0] div_by9(input logic [11:0] y);
        logic [23:0] p;
        logic [11:0] q0;
        logic [15:0] t;
        p  = 24'(y) * 24'd910;
        q0 = 12'(p[23:13]);
        t  = 16'(y) - 16'(q0) * 16'd9;
        return (t >= 16'd9) ? q0 + 12'd1 : q0;
    endfunction

    // floor((2*s + n) / (2*n)) for n in {1,2,3,4,6,9}
    function automatic logic [7:0] round_mean(input logic [SUM_W-1:0] s,
                                              input logic [CNT_W-1:0] n);
        logic [11:0] y;
        logic [11:0] q;
        y = s + 12'(n >> 1);
        case (n)
            4'd2:    q = y >> 1;
            4'd3:    q = div_by3(y);
            4'd4:    q = y >> 2;
            4'd6:    q = div_by3(y >> 1);
            4'd9:    q = div_by9(y);
            default: q = y;
        endcase
        return q[7:0];
    endfunction

    // one window column, rows masked by validity
    function automatic logic [9:0] col_sum(input logic [7:0] t, input logic [7:0] m,
                                           input logic [7:0] b, input logic t_ok,
                                           input logic b_ok);
        return (t_ok ? 10'(t) : 10'd0) + 10'(m) + (b_ok ? 10'(b) : 10'd0);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/box_blur_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3
// Streaming 3x3 box blur, edge clipped, over raster-order RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   pix_* : input channel. kind = 0 carries a pixel, kind = 1 is a flush tick
//           that drains the final row. A transaction completes on a rising
//           edge with pix_valid high and pix_stall low. Items of the wrong
//           kind for the current phase are taken and dropped.
//   res_* : output channel, same valid/stall rules. Each input transaction
//           yields zero, one or two results; last_of_run marks the final one.
//   cfg_* : register writes (image_width, image_height); cfg_ready is always
//           high. Write only while the block is idle.
// Sequence:
//   Each item passes through IDLE (taken), SUM (line-memory read-modify-write
//   and window sums), then DIV_A and/or DIV_B, one per result, which share
//   one round/divide stage and wait while res_stall holds the output. A new
//   item is taken only in IDLE; output lags input by one row and one pixel.
// Reset:
//   Counters and window clear, width = 640, height = 480. Line memories are
//   not cleared; unwritten entries never reach an output.
// Stall:
//   The output register holds while res_stall is high; the divide stage waits
//   for it, and pix_stall stays high until the item is finished.
// ----------------------------------------------------------------------------
module box_blur_3x3 #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          pix_valid,
    output logic                         pix_stall,
    input  wire bb3_pkg::pix_item_t      pix_data,
    output logic                         res_valid,
    input  wire                          res_stall,
    output bb3_pkg::res_item_t           res_data,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [bb3_pkg::CFG_W-1:0]     cfg_data
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);                    // column index width
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;    // clamped width

    // ---- configuration ----
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_W'(640);
            image_height_reg <= CFG_W'(480);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_IMAGE_WIDTH)
                image_width_reg <= cfg_data;
            else if (cfg_index == REG_IMAGE_HEIGHT)
                image_height_reg <= cfg_data;
        end
    end

    // ---- frame position ----
    bb3_state_t state_reg, state_next;

    logic [CW-1:0]    column_count_reg;
    logic [CW-1:0]    drain_count_reg;
    logic [CFG_W-1:0] row_count_reg;

    logic [WW-1:0]    wlim, wlast, cand;
    logic [CFG_W-1:0] hlim;
    logic             drain, accept, take, last;
    logic [CW-1:0]    col;

    always_comb
    begin
        if (image_width_reg == '0)
            wlim = WW'(1);
        else if (WW'(image_width_reg) > WW'(MAX_WIDTH))
            wlim = WW'(MAX_WIDTH);
        else
            wlim = WW'(image_width_reg);
        wlast = wlim - WW'(1);
        hlim  = (image_height_reg == '0) ? CFG_W'(1) : image_height_reg;
        drain = row_count_reg >= hlim;
        cand  = drain ? WW'(drain_count_reg) : WW'(column_count_reg);
        col   = (cand > wlast) ? wlast[CW-1:0] : cand[CW-1:0];
        last  = (WW'(col) == wlast);
    end

    assign accept = pix_valid && !pix_stall;
    assign take   = accept && (pix_data.kind == drain);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            drain_count_reg  <= '0;
            row_count_reg    <= '0;
        end
        else if (take)
        begin
            if (drain)
            begin
                if (last)
                begin
                    drain_count_reg  <= '0;
                    column_count_reg <= '0;
                    row_count_reg    <= '0;
                end
                else
                    drain_count_reg <= col + CW'(1);
            end
            else if (last)
            begin
                column_count_reg <= '0;
                row_count_reg    <= row_count_reg + CFG_W'(1);
            end
            else
                column_count_reg <= col + CW'(1);
        end
    end

    // ---- per-item latch (taken transaction) ----
    logic [CW-1:0] col_reg;
    logic [23:0]   cur_reg;
    logic          drain_reg, emit_a_reg, emit_b_reg;
    logic          row_ge2_reg, col_ge1_reg, col_ge2_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            col_reg     <= col;
            cur_reg     <= drain ? 24'd0
                                 : {pix_data.red_in, pix_data.green_in, pix_data.blue_in};
            drain_reg   <= drain;
            emit_a_reg  <= (row_count_reg != '0) && (col != '0);
            emit_b_reg  <= (row_count_reg != '0) && last;
            row_ge2_reg <= row_count_reg >= CFG_W'(2);
            col_ge1_reg <= col >= CW'(1);
            col_ge2_reg <= col >= CW'(2);
        end
    end

    // ---- line memory: {older row, newer row} per column ----
    logic [47:0] line_mem [MAX_WIDTH];
    logic [47:0] rd_reg;
    logic        mem_we;
    logic [23:0] top, mid;

    assign top    = rd_reg[47:24];
    assign mid    = rd_reg[23:0];
    assign mem_we = (state_reg == ST_SUM) && !drain_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[col_reg] <= {mid, cur_reg};
        if (take)
            rd_reg <= line_mem[col];
    end

    // ---- window and sums ----
    logic [23:0]      win_reg [6];
    logic [SUM_W-1:0] sum_a_next [3];
    logic [SUM_W-1:0] sum_b_next [3];
    logic [SUM_W-1:0] sum_a_reg  [3];
    logic [SUM_W-1:0] sum_b_reg  [3];
    logic [CNT_W-1:0] cnt_a_reg, cnt_b_reg;
    logic [CNT_W-1:0] nrows;

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_a_next[ch] =
                (col_ge2_reg ? SUM_W'(col_sum(win_reg[3][ch*8 +: 8], win_reg[4][ch*8 +: 8],
                                              win_reg[5][ch*8 +: 8], row_ge2_reg,
                                              !drain_reg)) : SUM_W'(0))
              + SUM_W'(col_sum(win_reg[0][ch*8 +: 8], win_reg[1][ch*8 +: 8],
                               win_reg[2][ch*8 +: 8], row_ge2_reg, !drain_reg))
              + SUM_W'(col_sum(top[ch*8 +: 8], mid[ch*8 +: 8], cur_reg[ch*8 +: 8],
                               row_ge2_reg, !drain_reg));
            sum_b_next[ch] =
                (col_ge1_reg ? SUM_W'(col_sum(win_reg[0][ch*8 +: 8], win_reg[1][ch*8 +: 8],
                                              win_reg[2][ch*8 +: 8], row_ge2_reg,
                                              !drain_reg)) : SUM_W'(0))
              + SUM_W'(col_sum(top[ch*8 +: 8], mid[ch*8 +: 8], cur_reg[ch*8 +: 8],
                               row_ge2_reg, !drain_reg));
        end
        nrows = CNT_W'(1) + CNT_W'(row_ge2_reg) + CNT_W'(!drain_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (state_reg == ST_SUM)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top;
            win_reg[1] <= mid;
            win_reg[2] <= cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            cnt_a_reg <= nrows * (CNT_W'(2) + CNT_W'(col_ge2_reg));
            cnt_b_reg <= nrows * (CNT_W'(1) + CNT_W'(col_ge1_reg));
        end
    end

    // ---- control ----
    logic load_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pix_stall  = 1'b1;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pix_stall = 1'b0;
                if (pix_valid && (pix_data.kind == drain))
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (emit_a_reg)
                    state_next = ST_DIV_A;
                else if (emit_b_reg)
                    state_next = ST_DIV_B;
                else
                    state_next = ST_IDLE;
            end
            ST_DIV_A:
            begin
                if (!res_valid || !res_stall)
                begin
                    load_out   = 1'b1;
                    state_next = emit_b_reg ? ST_DIV_B : ST_IDLE;
                end
            end
            ST_DIV_B:
            begin
                if (!res_valid || !res_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---- round/divide and output register ----
    logic             sel_b;
    logic [SUM_W-1:0] div_sum [3];
    logic [CNT_W-1:0] div_cnt;
    res_item_t        res_next;

    always_comb
    begin
        sel_b   = (state_reg == ST_DIV_B);
        div_cnt = sel_b ? cnt_b_reg : cnt_a_reg;
        for (int ch = 0; ch < 3; ch++)
            div_sum[ch] = sel_b ? sum_b_reg[ch] : sum_a_reg[ch];
        res_next.red_out      = round_mean(div_sum[2], div_cnt);
        res_next.green_out    = round_mean(div_sum[1], div_cnt);
        res_next.blue_out     = round_mean(div_sum[0], div_cnt);
        res_next.end_of_frame = sel_b && drain_reg;
        res_next.last_of_run  = sel_b || !emit_b_reg;
    end

    logic res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (load_out)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            res_data <= res_next;
    end

    assign res_valid = res_valid_reg;

endmodule
`default_nettype wire
